FILE: hdl/hdwf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdwf_pkg
// Shared widths, word types and register codes of the virtual wall force block.
// ----------------------------------------------------------------------------
package hdwf_pkg;

	localparam int POS_W      = 24;
	localparam int VEL_W      = 24;
	localparam int FRC_W      = 32;
	localparam int KP_W       = 16;
	localparam int KV_W       = 16;
	localparam int HW_W       = 23;
	localparam int OFF_W      = 24;
	localparam int MASK_W     = 4;
	localparam int NUM_AXES   = 3;
	localparam int AX_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int D_W        = POS_W + 1;
	localparam int SQ_W       = 2 * D_W;
	localparam int ROOT_W     = D_W;
	localparam int MA_W       = 41;
	localparam int MB_W       = 25;
	localparam int MP_W       = MA_W + MB_W;
	localparam int DQ_W       = 26;
	localparam int DD_W       = ROOT_W;
	localparam int DN_W       = DQ_W + DD_W;
	localparam int ACC_W      = 44;
	localparam int VDOT_W     = 51;
	localparam int M_W        = 51;
	localparam int N_W        = 23;
	localparam int NORM_SH    = 22;
	localparam int PROJ_SH    = 30;
	localparam int DAMP_SH    = 8;

	localparam int MUL_CNT_W  = $clog2(MB_W + 1);
	localparam int DIV_CNT_W  = $clog2(DQ_W + 1);
	localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

	localparam logic [M_W-1:0] M_CAP = M_W'(1) << 40;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_z;
	} in_word_t;

	typedef struct packed {
		logic signed [FRC_W-1:0] force_x;
		logic signed [FRC_W-1:0] force_y;
		logic signed [FRC_W-1:0] force_z;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STIFFNESS     = 3'd0,
		REG_DAMPING       = 3'd1,
		REG_ENABLE_MASK   = 3'd2,
		REG_HALF_WIDTH_X  = 3'd3,
		REG_HALF_WIDTH_Y  = 3'd4,
		REG_HALF_WIDTH_Z  = 3'd5,
		REG_CIRCLE_RADIUS = 3'd6,
		REG_CIRCLE_OFFSET = 3'd7
	} cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/hdwf_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdwf_smul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hdwf_smul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [hdwf_pkg::MA_W-1:0]   a,
	input  wire logic [hdwf_pkg::MB_W-1:0]   b,
	output logic                             done,
	output logic [hdwf_pkg::MP_W-1:0]        p
);
	import hdwf_pkg::*;

	logic [MA_W:0]          hi_q;
	logic [MB_W-1:0]        lo_q;
	logic [MA_W-1:0]        a_q;
	logic [MUL_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [MA_W:0]          sum;

	assign sum = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			a_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				hi_q   <= '0;
				lo_q   <= b;
				a_q    <= a;
				cnt_q  <= MUL_CNT_W'(MB_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hi_q  <= sum >> 1;
				lo_q  <= {sum[0], lo_q[MB_W-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = {hi_q[MA_W-1:0], lo_q};

endmodule
`default_nettype wire

FILE: hdl/hdwf_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdwf_sdiv
// Restoring divider, one quotient bit per cycle; quotient known to fit DQ_W.
// ----------------------------------------------------------------------------
module hdwf_sdiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [hdwf_pkg::DN_W-1:0]   num,
	input  wire logic [hdwf_pkg::DD_W-1:0]   den,
	output logic                             done,
	output logic [hdwf_pkg::DQ_W-1:0]        quo
);
	import hdwf_pkg::*;

	logic [DD_W-1:0]        rem_q;
	logic [DQ_W-1:0]        nsh_q;
	logic [DD_W-1:0]        den_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DD_W:0]          t;
	logic [DD_W:0]          diff;
	logic                   ge;

	assign t    = {rem_q, nsh_q[DQ_W-1]};
	assign ge   = t >= {1'b0, den_q};
	assign diff = t - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			nsh_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num[DN_W-1:DQ_W];
				nsh_q  <= num[DQ_W-1:0];
				den_q  <= den;
				cnt_q  <= DIV_CNT_W'(DQ_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DD_W-1:0] : t[DD_W-1:0];
				nsh_q <= {nsh_q[DQ_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = nsh_q;

endmodule
`default_nettype wire

FILE: hdl/hdwf_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdwf_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module hdwf_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [hdwf_pkg::SQ_W-1:0]    rad,
	output logic                              done,
	output logic [hdwf_pkg::ROOT_W-1:0]       root
);
	import hdwf_pkg::*;

	logic [SQ_W-1:0]         s_q;
	logic [ROOT_W:0]         rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic [SQRT_CNT_W-1:0]   cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [ROOT_W+2:0]       t;
	logic [ROOT_W+2:0]       trial;
	logic [ROOT_W+2:0]       diff;
	logic                    ge;

	assign t     = {rem_q, s_q[SQ_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = t >= trial;
	assign diff  = t - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			s_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				s_q    <= rad;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= SQRT_CNT_W'(ROOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				s_q    <= s_q << 2;
				rem_q  <= ge ? diff[ROOT_W:0] : t[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hdl/haptic_deadzone_wall_force.sv
`default_nettype none
// Each wall takes up to two serial multiplies, and the circle adds up to eight
// multiplies, one square root and up to three divides. One word is in work at
// a time; the next word is taken once the result is in the output register.
// Reset clears configuration and homing.
// ----------------------------------------------------------------------------
// haptic_deadzone_wall_force
// Dead-zone wall and circle spring/damper forces, sequenced over bit-serial
// multiply, divide and square-root units.
// ----------------------------------------------------------------------------
module haptic_deadzone_wall_force (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire hdwf_pkg::in_word_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output hdwf_pkg::out_word_t                    out_data,
	input  wire logic                              cfg_we,
	input  wire logic [hdwf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hdwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hdwf_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_WALL_P = 12'b000000000010,
		ST_WALL_D = 12'b000000000100,
		ST_SQ     = 12'b000000001000,
		ST_SQRT   = 12'b000000010000,
		ST_VD     = 12'b000000100000,
		ST_DIVV   = 12'b000001000000,
		ST_MKP    = 12'b000010000000,
		ST_MKV    = 12'b000100000000,
		ST_DIVN   = 12'b001000000000,
		ST_MN     = 12'b010000000000,
		ST_OUT    = 12'b100000000000
	} state_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
		if (v[POS_W] != v[POS_W-1])
			sat_pos = {v[POS_W], {(POS_W-1){~v[POS_W]}}};
		else
			sat_pos = v[POS_W-1:0];
	endfunction

	function automatic logic signed [FRC_W-1:0] sat_frc(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:FRC_W-1] != {(ACC_W-FRC_W+1){v[ACC_W-1]}})
			sat_frc = {v[ACC_W-1], {(FRC_W-1){~v[ACC_W-1]}}};
		else
			sat_frc = v[FRC_W-1:0];
	endfunction

	// configuration
	logic [KP_W-1:0]    kp_q;
	logic [KV_W-1:0]    kv_q;
	logic [MASK_W-1:0]  mask_q;
	logic [HW_W-1:0]    hw_q [NUM_AXES];
	logic [HW_W-1:0]    rad_q;
	logic [2*OFF_W-1:0] off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			kv_q   <= '0;
			mask_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) hw_q[i] <= '0;
			rad_q  <= '0;
			off_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_STIFFNESS:     kp_q     <= cfg_data[KP_W-1:0];
				REG_DAMPING:       kv_q     <= cfg_data[KV_W-1:0];
				REG_ENABLE_MASK:   mask_q   <= cfg_data[MASK_W-1:0];
				REG_HALF_WIDTH_X:  hw_q[0]  <= cfg_data[HW_W-1:0];
				REG_HALF_WIDTH_Y:  hw_q[1]  <= cfg_data[HW_W-1:0];
				REG_HALF_WIDTH_Z:  hw_q[2]  <= cfg_data[HW_W-1:0];
				REG_CIRCLE_RADIUS: rad_q    <= cfg_data[HW_W-1:0];
				REG_CIRCLE_OFFSET: off_q    <= cfg_data[2*OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// sample, homing and work registers
	state_t                    state_q;
	logic                      launched_q;
	logic                      homed_q;
	logic signed [POS_W-1:0]   pos_q  [NUM_AXES];
	logic signed [VEL_W-1:0]   vel_q  [NUM_AXES];
	logic signed [POS_W-1:0]   home_q [NUM_AXES];
	logic [AX_W-1:0]           plane_q [2];
	logic signed [POS_W-1:0]   ctr_q  [2];
	logic signed [ACC_W-1:0]   acc_q  [NUM_AXES];
	logic [AX_W-1:0]           ax_q;
	logic                      pl_q;
	logic [MA_W-1:0]           wtmp_q;
	logic [SQ_W-1:0]           s_q;
	logic [ROOT_W-1:0]         r_q;
	logic signed [VDOT_W-1:0]  vdot_q;
	logic [MB_W-1:0]           vrp_q;
	logic [M_W-1:0]            m_q;
	logic [N_W-1:0]            n_q;
	logic                      out_valid_q;
	out_word_t                 out_data_q;

	logic                      acc_in;
	logic signed [POS_W-1:0]   in_pos [NUM_AXES];
	logic signed [VEL_W-1:0]   in_vel [NUM_AXES];
	logic [AX_W-1:0]           prim, a0, a1;

	assign in_pos[0] = in_data.pos_x;
	assign in_pos[1] = in_data.pos_y;
	assign in_pos[2] = in_data.pos_z;
	assign in_vel[0] = in_data.vel_x;
	assign in_vel[1] = in_data.vel_y;
	assign in_vel[2] = in_data.vel_z;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_comb begin
		if (mask_q[0])      prim = AX_W'(0);
		else if (mask_q[1]) prim = AX_W'(1);
		else if (mask_q[2]) prim = AX_W'(2);
		else                prim = AX_W'(0);
		a0 = (prim == AX_W'(0)) ? AX_W'(1) : AX_W'(0);
		a1 = (prim == AX_W'(2)) ? AX_W'(1) : AX_W'(2);
	end

	// wall terms for the current axis
	logic signed [POS_W-1:0]  pos_a, home_a;
	logic signed [VEL_W-1:0]  vel_a;
	logic signed [D_W-1:0]    d_w;
	logic signed [D_W:0]      ex_p, ex_n;
	logic                     out_pos, out_neg, wall_act, outward;
	logic [D_W-1:0]           ex_mag;
	logic [VEL_W-1:0]         vel_mag;

	assign pos_a    = pos_q[ax_q];
	assign home_a   = home_q[ax_q];
	assign vel_a    = vel_q[ax_q];
	assign d_w      = {pos_a[POS_W-1], pos_a} - {home_a[POS_W-1], home_a};
	assign ex_p     = {d_w[D_W-1], d_w} - $signed({3'b0, hw_q[ax_q]});
	assign ex_n     = -{d_w[D_W-1], d_w} - $signed({3'b0, hw_q[ax_q]});
	assign out_pos  = !ex_p[D_W] && (ex_p != '0);
	assign out_neg  = !ex_n[D_W] && (ex_n != '0);
	assign ex_mag   = out_pos ? ex_p[D_W-1:0] : ex_n[D_W-1:0];
	assign wall_act = mask_q[ax_q] && (out_pos || out_neg);
	assign outward  = out_pos ? (!vel_a[VEL_W-1] && (vel_a != '0)) : vel_a[VEL_W-1];
	assign vel_mag  = vel_a[VEL_W-1] ? VEL_W'(-vel_a) : VEL_W'(vel_a);

	// circle terms for the current plane axis
	logic [AX_W-1:0]          pa;
	logic signed [POS_W-1:0]  pos_p, ctr_p;
	logic signed [VEL_W-1:0]  vel_p;
	logic signed [D_W-1:0]    dp;
	logic                     dp_neg, vp_neg;
	logic [D_W-1:0]           dp_mag;
	logic [VEL_W-1:0]         vp_mag;
	logic [ROOT_W-1:0]        depth;
	logic [VDOT_W-1:0]        vdot_mag;

	assign pa       = plane_q[pl_q];
	assign pos_p    = pos_q[pa];
	assign ctr_p    = ctr_q[pl_q];
	assign vel_p    = vel_q[pa];
	assign dp       = {pos_p[POS_W-1], pos_p} - {ctr_p[POS_W-1], ctr_p};
	assign dp_neg   = dp[D_W-1];
	assign dp_mag   = dp_neg ? D_W'(-dp) : D_W'(dp);
	assign vp_neg   = vel_p[VEL_W-1];
	assign vp_mag   = vp_neg ? VEL_W'(-vel_p) : VEL_W'(vel_p);
	assign depth    = r_q - ROOT_W'(rad_q);
	assign vdot_mag = vdot_q[VDOT_W-1] ? VDOT_W'(-vdot_q) : VDOT_W'(vdot_q);

	// shared units
	logic               mul_start, mul_go, mul_done;
	logic [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]    mul_b;
	logic [MP_W-1:0]    mul_p;
	logic               div_start, div_done;
	logic [DN_W-1:0]    div_num;
	logic [DQ_W-1:0]    div_q;
	logic               sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]  sqrt_root;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_go = 1'b0;
		case (state_q)
			ST_WALL_P: begin
				mul_a  = MA_W'(kp_q);
				mul_b  = MB_W'(ex_mag);
				mul_go = wall_act;
			end
			ST_WALL_D: begin
				mul_a  = MA_W'(kv_q);
				mul_b  = MB_W'(vel_mag);
				mul_go = outward;
			end
			ST_SQ: begin
				mul_a  = MA_W'(dp_mag);
				mul_b  = MB_W'(dp_mag);
				mul_go = 1'b1;
			end
			ST_VD: begin
				mul_a  = MA_W'(vp_mag);
				mul_b  = MB_W'(dp_mag);
				mul_go = 1'b1;
			end
			ST_MKP: begin
				mul_a  = MA_W'(kp_q);
				mul_b  = MB_W'(depth);
				mul_go = 1'b1;
			end
			ST_MKV: begin
				mul_a  = MA_W'(kv_q);
				mul_b  = vrp_q;
				mul_go = (vrp_q != '0);
			end
			ST_MN: begin
				mul_a  = m_q[MA_W-1:0];
				mul_b  = MB_W'(n_q);
				mul_go = 1'b1;
			end
			default: ;
		endcase
	end

	assign mul_start  = mul_go && !launched_q;
	assign div_start  = ((state_q == ST_DIVV) || (state_q == ST_DIVN)) && !launched_q;
	assign sqrt_start = (state_q == ST_SQRT) && !launched_q;
	assign div_num    = ((state_q == ST_DIVV) ? vdot_mag : DN_W'({dp_mag, {NORM_SH{1'b0}}}))
		+ DN_W'(r_q >> 1);

	hdwf_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	hdwf_sdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (r_q),
		.done   (div_done),
		.quo    (div_q)
	);

	hdwf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (s_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// result arithmetic
	logic [MA_W:0]            wall_mag;
	logic signed [ACC_W-1:0]  wall_frc;
	logic [M_W-1:0]           m_sum;
	logic [MP_W-PROJ_SH-1:0]  proj;
	logic [MP_W-1:0]          proj_sum;

	assign wall_mag = {1'b0, wtmp_q} + (outward ? (MA_W+1)'((mul_p[MA_W:0]
		+ (MA_W+1)'(1 << (DAMP_SH - 1))) >> DAMP_SH) : '0);
	assign wall_frc = out_pos ? -$signed(ACC_W'(wall_mag)) : $signed(ACC_W'(wall_mag));
	assign m_sum    = m_q + ((vrp_q != '0) ? mul_p[M_W-1:0] : '0);
	assign proj_sum = mul_p + MP_W'(1 << (PROJ_SH - 1));
	assign proj     = proj_sum[MP_W-1:PROJ_SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			homed_q     <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				home_q[i] <= '0;
				pos_q[i]  <= '0;
				vel_q[i]  <= '0;
				acc_q[i]  <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				plane_q[i] <= '0;
				ctr_q[i]   <= '0;
			end
			ax_q        <= '0;
			pl_q        <= 1'b0;
			wtmp_q      <= '0;
			s_q         <= '0;
			r_q         <= '0;
			vdot_q      <= '0;
			vrp_q       <= '0;
			m_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							pos_q[i] <= in_pos[i];
							vel_q[i] <= in_vel[i];
							acc_q[i] <= '0;
						end
						if (!homed_q) begin
							for (int i = 0; i < NUM_AXES; i++) home_q[i] <= in_pos[i];
							plane_q[0] <= a0;
							plane_q[1] <= a1;
							ctr_q[0]   <= sat_pos({in_pos[a0][POS_W-1], in_pos[a0]}
								+ {off_q[OFF_W-1], off_q[OFF_W-1:0]});
							ctr_q[1]   <= sat_pos({in_pos[a1][POS_W-1], in_pos[a1]}
								+ {off_q[2*OFF_W-1], off_q[2*OFF_W-1:OFF_W]});
							homed_q    <= 1'b1;
						end
						ax_q    <= '0;
						state_q <= ST_WALL_P;
					end
				end
				ST_WALL_P: begin
					if (!wall_act) begin
						if (ax_q == AX_W'(NUM_AXES - 1)) begin
							pl_q    <= 1'b0;
							s_q     <= '0;
							state_q <= mask_q[3] ? ST_SQ : ST_OUT;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end else if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_done) begin
						launched_q <= 1'b0;
						wtmp_q     <= mul_p[MA_W-1:0];
						state_q    <= ST_WALL_D;
					end
				end
				ST_WALL_D: begin
					if (!outward || (launched_q && mul_done)) begin
						launched_q   <= 1'b0;
						acc_q[ax_q]  <= wall_frc;
						if (ax_q == AX_W'(NUM_AXES - 1)) begin
							pl_q    <= 1'b0;
							s_q     <= '0;
							state_q <= mask_q[3] ? ST_SQ : ST_OUT;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_WALL_P;
						end
					end else if (!launched_q) begin
						launched_q <= 1'b1;
					end
				end
				ST_SQ: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_done) begin
						launched_q <= 1'b0;
						s_q        <= s_q + mul_p[SQ_W-1:0];
						pl_q       <= ~pl_q;
						if (pl_q)
							state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (sqrt_done) begin
						launched_q <= 1'b0;
						r_q        <= sqrt_root;
						vdot_q     <= '0;
						state_q    <= (sqrt_root > ROOT_W'(rad_q)) ? ST_VD : ST_OUT;
					end
				end
				ST_VD: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_done) begin
						launched_q <= 1'b0;
						if (vp_neg ^ dp_neg)
							vdot_q <= vdot_q - $signed({2'b0, mul_p[VDOT_W-3:0]});
						else
							vdot_q <= vdot_q + $signed({2'b0, mul_p[VDOT_W-3:0]});
						pl_q <= ~pl_q;
						if (pl_q)
							state_q <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (div_done) begin
						launched_q <= 1'b0;
						vrp_q      <= (!vdot_q[VDOT_W-1]) ? div_q[MB_W-1:0] : '0;
						state_q    <= ST_MKP;
					end
				end
				ST_MKP: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_done) begin
						launched_q <= 1'b0;
						m_q        <= {mul_p[M_W-DAMP_SH-1:0], {DAMP_SH{1'b0}}};
						state_q    <= ST_MKV;
					end
				end
				ST_MKV: begin
					if ((vrp_q == '0) || (launched_q && mul_done)) begin
						launched_q <= 1'b0;
						m_q        <= (m_sum > M_CAP) ? M_CAP : m_sum;
						pl_q       <= 1'b0;
						state_q    <= ST_DIVN;
					end else if (!launched_q) begin
						launched_q <= 1'b1;
					end
				end
				ST_DIVN: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (div_done) begin
						launched_q <= 1'b0;
						n_q        <= div_q[N_W-1:0];
						state_q    <= ST_MN;
					end
				end
				ST_MN: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_done) begin
						launched_q <= 1'b0;
						if (dp_neg)
							acc_q[pa] <= acc_q[pa] + $signed(ACC_W'(proj));
						else
							acc_q[pa] <= acc_q[pa] - $signed(ACC_W'(proj));
						pl_q    <= ~pl_q;
						state_q <= pl_q ? ST_OUT : ST_DIVN;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_data_q.force_x <= sat_frc(acc_q[0]);
						out_data_q.force_y <= sat_frc(acc_q[1]);
						out_data_q.force_z <= sat_frc(acc_q[2]);
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside output state");
	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		homed_q |=> homed_q)
		else $error("homing flag dropped");
	a_accept_homes: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (homed_q && (state_q == ST_WALL_P)))
		else $error("accepted word did not home and start walls");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mul_start, div_start, sqrt_start}) <= 1)
		else $error("two units launched at once");
`endif

endmodule
`default_nettype wire
